// ----- src/swa_pkg.sv -----
// Shared constants for the sliding window average block.
package swa_pkg;

   localparam int DEF_MAX_WINDOW  = 64;
   localparam int DEF_SAMPLE_BITS = 32;

   localparam int LEN_FIELD_BITS = 7;   // width of the csr window length field
   localparam int HELD_BITS      = 7;   // width of the samples held result field
   localparam int LEN_MIN        = 2;
   localparam int LEN_RESET      = 8;

   localparam int JOB_DEPTH = 2;        // entries in the front-to-back queue

endpackage

// ----- src/swa_front.sv -----
// Front end: window length register, sample ring, running total and fill count.
module swa_front #(
   parameter int MAX_WINDOW  = 64,
   parameter int SAMPLE_BITS = 32,
   parameter int CNT_W       = $clog2(MAX_WINDOW + 1),
   parameter int TOT_W       = SAMPLE_BITS + $clog2(MAX_WINDOW)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swa_pkg::LEN_FIELD_BITS-1:0]  csr_data,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [SAMPLE_BITS-1:0]              req_sample,
   output logic                                job_push,
   input  logic                                job_full,
   output logic [TOT_W-1:0]                    job_total,
   output logic [CNT_W-1:0]                    job_count
);
   import swa_pkg::*;

   localparam int SLOT_W  = $clog2(MAX_WINDOW);
   localparam int LEN_RST = (LEN_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_RESET;

   logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] old_ff;
   logic [SAMPLE_BITS-1:0] samp_ff;

   logic [CNT_W-1:0]  len_ff, len_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic signed [TOT_W-1:0] total_ff, total_in;
   logic busy_ff, busy_in;
   logic evict_ff, evict_in;

   logic        csr_write;
   logic        accept;
   logic [31:0] wr_val;
   logic [31:0] len_sat;
   logic [CNT_W-1:0] slot_next;
   logic signed [TOT_W-1:0] old_ext;
   logic signed [TOT_W-1:0] new_ext;
   logic signed [TOT_W-1:0] sum;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign req_full  = busy_ff | job_full;
   assign accept    = req_push & ~req_full;

   assign wr_val  = 32'(csr_data);
   assign len_sat = (wr_val < 32'(LEN_MIN))    ? 32'(LEN_MIN)    :
                    (wr_val > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : wr_val;

   assign slot_next = CNT_W'(slot_ff) + CNT_W'(1);

   assign old_ext = {{(TOT_W-SAMPLE_BITS){old_ff[SAMPLE_BITS-1]}}, old_ff};
   assign new_ext = {{(TOT_W-SAMPLE_BITS){samp_ff[SAMPLE_BITS-1]}}, samp_ff};
   assign sum     = total_ff - (evict_ff ? old_ext : '0) + new_ext;

   always_comb begin
      len_in   = len_ff;
      count_in = count_ff;
      slot_in  = slot_ff;
      total_in = total_ff;
      busy_in  = busy_ff;
      evict_in = evict_ff;
      priority if (csr_write) begin
         // a new length clears the window
         len_in   = CNT_W'(len_sat);
         count_in = '0;
         slot_in  = '0;
         total_in = '0;
         busy_in  = 1'b0;
      end else if (accept) begin
         busy_in  = 1'b1;
         evict_in = (count_ff == len_ff);
         if (count_ff != len_ff) begin
            count_in = count_ff + CNT_W'(1);
         end
         slot_in = (slot_next >= len_ff) ? '0 : slot_next[SLOT_W-1:0];
      end else if (busy_ff) begin
         busy_in  = 1'b0;
         total_in = sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= CNT_W'(LEN_RST);
         count_ff <= '0;
         slot_ff  <= '0;
         total_ff <= '0;
         busy_ff  <= 1'b0;
         evict_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         count_ff <= count_in;
         slot_ff  <= slot_in;
         total_ff <= total_in;
         busy_ff  <= busy_in;
         evict_ff <= evict_in;
      end
   end

   // read-first ring: the old sample comes out as the new one goes in
   always_ff @(posedge clock) begin
      if (accept) begin
         old_ff        <= ring[slot_ff];
         ring[slot_ff] <= req_sample;
         samp_ff       <= req_sample;
      end
   end

   assign job_push  = busy_ff;
   assign job_total = sum;
   assign job_count = count_ff;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("front pushed into a full queue");
   a_count_le_len: assert property (@(posedge clock) disable iff (reset)
      count_ff <= len_ff)
      else $error("fill count exceeds window length");
   a_slot_lt_len: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(slot_ff) < len_ff)
      else $error("write slot outside the window");

endmodule

// ----- src/swa_fifo.sv -----
// Short queue of running totals and counts between front and back.
module swa_fifo #(
   parameter int WIDTH = 45
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   import swa_pkg::*;

   localparam int PTR_W = $clog2(JOB_DEPTH);

   logic [WIDTH-1:0] mem [JOB_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full    = (cnt_ff == (PTR_W+1)'(JOB_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(JOB_DEPTH-1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(JOB_DEPTH-1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + (PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - (PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

   assign pop_data = mem[rd_ff];

endmodule

// ----- src/swa_back.sv -----
// Back end: sequential signed divide of running total by count, result register.
module swa_back #(
   parameter int SAMPLE_BITS = 32,
   parameter int CNT_W       = 7,
   parameter int TOT_W       = 38
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   output logic                           job_pop,
   input  logic [TOT_W-1:0]               job_total,
   input  logic [CNT_W-1:0]               job_count,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [SAMPLE_BITS-1:0]         rsp_average,
   output logic [swa_pkg::HELD_BITS-1:0]  rsp_samples_held
);
   import swa_pkg::*;

   localparam int STEP_W = $clog2(TOT_W);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_HOLD   = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [TOT_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic              out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] avg_ff, avg_in;
   logic [HELD_BITS-1:0]   held_ff, held_in;

   logic [CNT_W:0]   trial;
   logic             fits;
   logic [TOT_W-1:0] mag;
   logic [TOT_W-1:0] signed_quo;
   logic             load;

   assign mag        = job_total[TOT_W-1] ? (~job_total + TOT_W'(1)) : job_total;
   assign trial      = {rem_ff, quo_ff[TOT_W-1]};
   assign fits       = (trial >= (CNT_W+1)'(den_ff));
   assign signed_quo = neg_ff ? (~quo_ff + TOT_W'(1)) : quo_ff;
   assign job_pop    = (state_ff == ST_IDLE) & job_valid;
   assign load       = (state_ff == ST_HOLD) & (~out_valid_ff | rsp_pop);

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff;
      avg_in       = avg_ff;
      held_in      = held_ff;
      if (rsp_pop && out_valid_ff) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               quo_in   = mag;
               rem_in   = '0;
               den_in   = job_count;
               neg_in   = job_total[TOT_W-1];
               step_in  = STEP_W'(TOT_W-1);
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // restoring step: one quotient bit per cycle
            rem_in = fits ? CNT_W'(trial - (CNT_W+1)'(den_ff)) : trial[CNT_W-1:0];
            quo_in = {quo_ff[TOT_W-2:0], fits};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (load) begin
               avg_in       = signed_quo[SAMPLE_BITS-1:0];
               held_in      = HELD_BITS'(den_ff);
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      avg_ff  <= avg_in;
      held_ff <= held_in;
   end

   assign rsp_empty        = ~out_valid_ff;
   assign rsp_average      = avg_ff;
   assign rsp_samples_held = held_ff;

   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> den_ff != '0)
      else $error("divide started with a zero count");
   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> state_ff == ST_DIVIDE)
      else $error("queue pop did not start a divide");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_pop && !rsp_empty && !load |=> rsp_empty)
      else $error("result register kept a taken request");

endmodule

// ----- src/sliding_window_average.sv -----
// Sliding window average: top level joining front, queue and divider back end.
//
// Boxcar moving average over signed fixed-point samples. Each request pushes
// one sample; the block keeps the last window_length samples in a ring, an
// exact running total and a fill count, and returns one result per request:
// the total divided by the count, truncated toward zero, plus the count.
// The front end takes a request whenever it is not busy and the two-entry
// queue has room; in its busy state it updates the total with the new sample
// and the evicted one read from the ring, then hands the total and count to
// the back end. The back end is a radix-2 restoring divider that produces one
// quotient bit per cycle, one per bit of the TOT_W-bit total (TOT_W =
// SAMPLE_BITS + log2(MAX_WINDOW)), and takes no new request until its result
// is loaded; it sets the sustained rate. A finished result waits in an output
// register while the next division runs. Writing the csr channel sets the
// window length (clamped to 2..MAX_WINDOW) and clears the window; do so only
// while no request is in flight. When the block is empty, an accepted push
// goes through front busy, queue, back idle, divide and hold to the rsp ports.
module sliding_window_average #(
   parameter int MAX_WINDOW  = swa_pkg::DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = swa_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swa_pkg::LEN_FIELD_BITS-1:0]  csr_data,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [SAMPLE_BITS-1:0]       rsp_average,
   output logic [swa_pkg::HELD_BITS-1:0]       rsp_samples_held
);
   import swa_pkg::*;

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int TOT_W = SAMPLE_BITS + $clog2(MAX_WINDOW);
   localparam int JOB_W = TOT_W + CNT_W;

   logic             job_push;
   logic             job_full;
   logic [TOT_W-1:0] job_total_front;
   logic [CNT_W-1:0] job_count_front;
   logic             job_empty;
   logic             job_pop;
   logic [JOB_W-1:0] job_out;

   // Front: hold the window length, update the ring and running total.
   swa_front #(
      .MAX_WINDOW  (MAX_WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .TOT_W       (TOT_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_sample (req_sample),
      .job_push   (job_push),
      .job_full   (job_full),
      .job_total  (job_total_front),
      .job_count  (job_count_front)
   );

   // Queue: decouple the front update from the long division.
   swa_fifo #(
      .WIDTH (JOB_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data ({job_total_front, job_count_front}),
      .full      (job_full),
      .pop       (job_pop),
      .empty     (job_empty),
      .pop_data  (job_out)
   );

   // Back: divide the total by the count, hold the result until popped.
   swa_back #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CNT_W       (CNT_W),
      .TOT_W       (TOT_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (~job_empty),
      .job_pop          (job_pop),
      .job_total        (job_out[JOB_W-1:CNT_W]),
      .job_count        (job_out[CNT_W-1:0]),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_average      (rsp_average),
      .rsp_samples_held (rsp_samples_held)
   );

endmodule
